// ===== design/cube_face_ray_mapping_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef CUBE_FACE_RAY_MAPPING_UNIT_MACROS_SVH
`define CUBE_FACE_RAY_MAPPING_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfrm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfrm assertion failed");

`endif

// ===== design/cfrm_pkg.sv =====
`default_nettype none
package cfrm_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int MAX_FACE_SIZE   = 4096;

    localparam int ANG_W        = 21;   // Q16 angles
    localparam int CW           = 27;   // CORDIC x/y, Q24
    localparam int VW           = CW + 1;
    localparam int NUM_W        = 44;   // divider numerator / remainder
    localparam int DEN_W        = 27;   // divider denominator
    localparam int QW           = COORD_FRAC_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int CFG_W        = 15;
    localparam int SIZE_W       = 13;
    localparam int PIX_W        = 12;

    localparam logic signed [ANG_W-1:0] Q_PI_4  = 21'sd51472;
    localparam logic signed [ANG_W-1:0] Q_PI_2  = 21'sd102944;
    localparam logic signed [ANG_W-1:0] Q_PI    = 21'sd205887;
    localparam logic signed [ANG_W-1:0] Q_3PI_2 = 21'sd308831;
    localparam logic signed [ANG_W-1:0] Q_2PI   = 21'sd411775;

    localparam logic signed [CW-1:0] CORDIC_K = 27'sd10188014;

    localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
        16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
    };

    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_LEFT   = 3'd1;
    localparam logic [2:0] FACE_REAR   = 3'd2;
    localparam logic [2:0] FACE_RIGHT  = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    localparam logic [1:0] CFG_MIN_AZ = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic                    neg;
        logic signed [ANG_W-1:0] t;
    } t_red;

    // Fold an angle into [-pi/2, pi/2], flagging a half-turn
    function automatic t_red reduce_angle(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] w;
        t_red r;
        w = a;
        if (w >= Q_PI) w = w - Q_2PI;
        if (w < -Q_PI) w = w + Q_2PI;
        r.neg = 1'b0;
        if (w > Q_PI_2) begin
            w     = w - Q_PI;
            r.neg = 1'b1;
        end else if (w < -Q_PI_2) begin
            w     = w + Q_PI;
            r.neg = 1'b1;
        end
        r.t = w;
        return r;
    endfunction

    // Turn quotient magnitude into a clamped face coordinate
    function automatic logic [COORD_FRAC_BITS:0] finish_coord(
        input logic [QW-1:0] q,
        input logic          neg,
        input logic          sat,
        input logic          dz
    );
        logic signed [COORD_FRAC_BITS+1:0] rh;
        logic signed [COORD_FRAC_BITS+1:0] rq;
        logic signed [COORD_FRAC_BITS+1:0] r;
        logic [COORD_FRAC_BITS:0]          res;
        rh = $signed({2'b00, 1'b1, {(COORD_FRAC_BITS-1){1'b0}}});
        rq = $signed({2'b00, q});
        r  = neg ? (rh - rq) : (rh + rq);
        if (dz) begin
            res = rh[COORD_FRAC_BITS:0];
        end else if (sat) begin
            res = neg ? '0 : {1'b1, {COORD_FRAC_BITS{1'b0}}};
        end else if (r < 0) begin
            res = '0;
        end else if (r[COORD_FRAC_BITS+1:COORD_FRAC_BITS] != 2'b00
                     && r[COORD_FRAC_BITS-1:0] != '0) begin
            res = {1'b1, {COORD_FRAC_BITS{1'b0}}};
        end else begin
            res = r[COORD_FRAC_BITS:0];
        end
        return res;
    endfunction

    // Image size saturated to 1..MAX_FACE_SIZE, minus one
    function automatic logic [PIX_W-1:0] size_m1(input logic [SIZE_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v == '0) res = '0;
        else if (v > SIZE_W'(MAX_FACE_SIZE)) res = PIX_W'(MAX_FACE_SIZE - 1);
        else res = PIX_W'(v - 1'b1);
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/cube_face_ray_mapping_unit.sv =====
// Cube-map face selection for laser rays, fully pipelined.
// Throughput: one request per cycle while the output is not stalled; the datapath
// holds 16 CORDIC stages and a 16-stage restoring divider, each stage one
// add/compare. Bubbles collapse under stall.
// Reset (synchronous, active low) empties the pipeline and restores cfg registers.
`default_nettype none
module cube_face_ray_mapping_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [1:0]                           i_cfg_idx,
    input  wire logic [cfrm_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [14:0]                   i_azimuth,
    input  wire logic signed [13:0]                   i_elevation,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [2:0]                                o_face,
    output logic [cfrm_pkg::COORD_FRAC_BITS:0]        o_face_u,
    output logic [cfrm_pkg::COORD_FRAC_BITS:0]        o_face_v,
    output logic [cfrm_pkg::PIX_W-1:0]                o_pixel_x,
    output logic [cfrm_pkg::PIX_W-1:0]                o_pixel_y,
    output logic                                      o_bad_angle
);
    import cfrm_pkg::*;

    localparam int ST_M = CORDIC_STEPS + 1;
    localparam int ST_F = ST_M + 1;
    localparam int ST_P = ST_F + 1;
    localparam int ST_R = ST_P + QW + 1;
    localparam int ST_O = ST_R + 1;
    localparam int NSTG = ST_O + 1;

    // configuration registers
    logic signed [14:0]  r_min_az;
    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_az <= '0;
            r_width  <= SIZE_W'(1024);
            r_height <= SIZE_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_AZ: r_min_az <= i_cfg_data[14:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits and per-stage advance (bubbles collapse)
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    assign w_adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[NSTG-1];

    // input stage: relative azimuth, sector and angle folding
    logic signed [15:0]      w_rel;
    logic signed [ANG_W-1:0] w_a16;
    logic signed [ANG_W-1:0] w_te;
    logic [1:0]              w_sec;
    t_red                    w_ra;
    t_red                    w_re;

    assign w_rel = {i_azimuth[14], i_azimuth} - {r_min_az[14], r_min_az};
    assign w_a16 = {w_rel[15], w_rel, 4'b0000};
    assign w_te  = {{3{i_elevation[13]}}, i_elevation, 4'b0000};
    assign w_ra  = reduce_angle(w_a16 - Q_PI_4);
    assign w_re  = reduce_angle(w_te);

    always_comb begin
        if (w_a16 < Q_PI_2)       w_sec = FACE_FRONT[1:0];
        else if (w_a16 < Q_PI)    w_sec = FACE_LEFT[1:0];
        else if (w_a16 < Q_3PI_2) w_sec = FACE_REAR[1:0];
        else                      w_sec = FACE_RIGHT[1:0];
    end

    // CORDIC stages, azimuth and elevation side by side
    logic signed [CW-1:0]    r_xa [0:CORDIC_STEPS];
    logic signed [CW-1:0]    r_ya [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_za [0:CORDIC_STEPS];
    logic signed [CW-1:0]    r_xe [0:CORDIC_STEPS];
    logic signed [CW-1:0]    r_ye [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_ze [0:CORDIC_STEPS];
    logic                    r_nega [0:CORDIC_STEPS];
    logic                    r_nege [0:CORDIC_STEPS];
    logic [1:0]              r_sec  [0:CORDIC_STEPS];
    logic                    r_bad  [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_xa[0]   <= CORDIC_K;
            r_ya[0]   <= '0;
            r_za[0]   <= w_ra.t;
            r_xe[0]   <= CORDIC_K;
            r_ye[0]   <= '0;
            r_ze[0]   <= w_re.t;
            r_nega[0] <= w_ra.neg;
            r_nege[0] <= w_re.neg;
            r_sec[0]  <= w_sec;
            r_bad[0]  <= w_rel[15];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        logic signed [ANG_W-1:0] w_at;
        assign w_at = $signed({{(ANG_W-16){1'b0}}, ATAN_TAB[k]});

        always_ff @(posedge i_clk) begin
            if (w_adv[k+1]) begin
                if (r_za[k] >= 0) begin
                    r_xa[k+1] <= r_xa[k] - (r_ya[k] >>> k);
                    r_ya[k+1] <= r_ya[k] + (r_xa[k] >>> k);
                    r_za[k+1] <= r_za[k] - w_at;
                end else begin
                    r_xa[k+1] <= r_xa[k] + (r_ya[k] >>> k);
                    r_ya[k+1] <= r_ya[k] - (r_xa[k] >>> k);
                    r_za[k+1] <= r_za[k] + w_at;
                end
                if (r_ze[k] >= 0) begin
                    r_xe[k+1] <= r_xe[k] - (r_ye[k] >>> k);
                    r_ye[k+1] <= r_ye[k] + (r_xe[k] >>> k);
                    r_ze[k+1] <= r_ze[k] - w_at;
                end else begin
                    r_xe[k+1] <= r_xe[k] + (r_ye[k] >>> k);
                    r_ye[k+1] <= r_ye[k] - (r_xe[k] >>> k);
                    r_ze[k+1] <= r_ze[k] + w_at;
                end
                r_nega[k+1] <= r_nega[k];
                r_nege[k+1] <= r_nege[k];
                r_sec[k+1]  <= r_sec[k];
                r_bad[k+1]  <= r_bad[k];
            end
        end
    end

    // direction vector: two products, floor shift by 24
    logic signed [CW-1:0]     w_ca, w_sa, w_ce, w_se;
    logic signed [2*CW-1:0]   w_pa, w_pb;
    logic signed [VW-1:0]     r_vx, r_vy, r_vz;
    logic [1:0]               r_sec_m;
    logic                     r_bad_m;

    assign w_ca = r_nega[CORDIC_STEPS] ? -r_xa[CORDIC_STEPS] : r_xa[CORDIC_STEPS];
    assign w_sa = r_nega[CORDIC_STEPS] ? -r_ya[CORDIC_STEPS] : r_ya[CORDIC_STEPS];
    assign w_ce = r_nege[CORDIC_STEPS] ? -r_xe[CORDIC_STEPS] : r_xe[CORDIC_STEPS];
    assign w_se = r_nege[CORDIC_STEPS] ? -r_ye[CORDIC_STEPS] : r_ye[CORDIC_STEPS];
    assign w_pa = w_ca * w_ce;
    assign w_pb = w_sa * w_ce;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_M]) begin
            r_vx    <= w_pa[24+VW-1:24];
            r_vy    <= w_pb[24+VW-1:24];
            r_vz    <= {w_se[CW-1], w_se};
            r_sec_m <= r_sec[CORDIC_STEPS];
            r_bad_m <= r_bad[CORDIC_STEPS];
        end
    end

    // face choice and plane components
    logic signed [VW-1:0] w_ax, w_ay, w_az;
    logic [2:0]           w_face;
    logic signed [VW-1:0] w_d, w_cu, w_cv;
    logic signed [VW-1:0] r_d, r_cu, r_cv;
    logic [2:0]           r_face_f;
    logic                 r_bad_f;

    assign w_ax = (r_vx < 0) ? -r_vx : r_vx;
    assign w_ay = (r_vy < 0) ? -r_vy : r_vy;
    assign w_az = (r_vz < 0) ? -r_vz : r_vz;

    always_comb begin
        if (w_az > w_ax && w_az > w_ay) w_face = (r_vz >= 0) ? FACE_TOP : FACE_BOTTOM;
        else                            w_face = {1'b0, r_sec_m};
        unique case (w_face)
            FACE_FRONT: begin w_d = r_vx;  w_cu = -r_vy; w_cv = -r_vz; end
            FACE_LEFT:  begin w_d = r_vy;  w_cu = r_vx;  w_cv = -r_vz; end
            FACE_REAR:  begin w_d = -r_vx; w_cu = r_vy;  w_cv = -r_vz; end
            FACE_RIGHT: begin w_d = -r_vy; w_cu = -r_vx; w_cv = -r_vz; end
            FACE_TOP:   begin w_d = r_vz;  w_cu = -r_vy; w_cv = r_vx;  end
            default:    begin w_d = -r_vz; w_cu = -r_vy; w_cv = -r_vx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_F]) begin
            r_d      <= w_d;
            r_cu     <= w_cu;
            r_cv     <= w_cv;
            r_face_f <= w_face;
            r_bad_f  <= r_bad_m;
        end
    end

    // divider set-up: magnitudes, signs, overflow and zero tests
    logic [VW-1:0]    w_cu_mag, w_cv_mag, w_d_mag;
    logic [NUM_W-1:0] w_nu, w_nv, w_dtop;

    assign w_cu_mag = (r_cu < 0) ? VW'(-r_cu) : VW'(r_cu);
    assign w_cv_mag = (r_cv < 0) ? VW'(-r_cv) : VW'(r_cv);
    assign w_d_mag  = (r_d < 0) ? VW'(-r_d) : VW'(r_d);
    assign w_nu     = NUM_W'({w_cu_mag, {(COORD_FRAC_BITS-1){1'b0}}});
    assign w_nv     = NUM_W'({w_cv_mag, {(COORD_FRAC_BITS-1){1'b0}}});
    assign w_dtop   = NUM_W'({w_d_mag[DEN_W-1:0], {COORD_FRAC_BITS{1'b0}}});

    logic [NUM_W-1:0] r_ru [0:QW-1];
    logic [NUM_W-1:0] r_rv [0:QW-1];
    logic [QW-1:0]    r_qu [0:QW];
    logic [QW-1:0]    r_qv [0:QW];
    logic [DEN_W-1:0] r_dd [0:QW-1];
    logic             r_su [0:QW];
    logic             r_sv [0:QW];
    logic             r_satu [0:QW];
    logic             r_satv [0:QW];
    logic             r_dz [0:QW];
    logic [2:0]       r_face_d [0:QW];
    logic             r_bad_d  [0:QW];

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_P]) begin
            r_ru[0]     <= w_nu;
            r_rv[0]     <= w_nv;
            r_qu[0]     <= '0;
            r_qv[0]     <= '0;
            r_dd[0]     <= w_d_mag[DEN_W-1:0];
            r_su[0]     <= (r_cu < 0) ^ (r_d < 0);
            r_sv[0]     <= (r_cv < 0) ^ (r_d < 0);
            r_satu[0]   <= (w_nu >= w_dtop);
            r_satv[0]   <= (w_nv >= w_dtop);
            r_dz[0]     <= (r_d == 0);
            r_face_d[0] <= r_face_f;
            r_bad_d[0]  <= r_bad_f;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        logic [NUM_W-1:0] w_sh;
        logic             w_tu, w_tv;
        assign w_sh = NUM_W'(r_dd[j]) << B;
        assign w_tu = (r_ru[j] >= w_sh);
        assign w_tv = (r_rv[j] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (w_adv[ST_P+j+1]) begin
                r_qu[j+1]     <= {r_qu[j][QW-2:0], w_tu};
                r_qv[j+1]     <= {r_qv[j][QW-2:0], w_tv};
                r_su[j+1]     <= r_su[j];
                r_sv[j+1]     <= r_sv[j];
                r_satu[j+1]   <= r_satu[j];
                r_satv[j+1]   <= r_satv[j];
                r_dz[j+1]     <= r_dz[j];
                r_face_d[j+1] <= r_face_d[j];
                r_bad_d[j+1]  <= r_bad_d[j];
            end
        end

        if (j < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_adv[ST_P+j+1]) begin
                    r_ru[j+1] <= w_tu ? (r_ru[j] - w_sh) : r_ru[j];
                    r_rv[j+1] <= w_tv ? (r_rv[j] - w_sh) : r_rv[j];
                    r_dd[j+1] <= r_dd[j];
                end
            end
        end
    end

    // coordinate: half plus signed quotient, clamped
    logic [COORD_FRAC_BITS:0] r_u, r_v;
    logic [2:0]               r_face_r;
    logic                     r_bad_r;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_R]) begin
            r_u      <= finish_coord(r_qu[QW], r_su[QW], r_satu[QW], r_dz[QW]);
            r_v      <= finish_coord(r_qv[QW], r_sv[QW], r_satv[QW], r_dz[QW]);
            r_face_r <= r_face_d[QW];
            r_bad_r  <= r_bad_d[QW];
        end
    end

    // pixel indices and output register
    logic [PIX_W-1:0]                 w_wm1, w_hm1;
    logic [COORD_FRAC_BITS+PIX_W:0]   w_px, w_py;

    assign w_wm1 = size_m1(r_width);
    assign w_hm1 = size_m1(r_height);
    assign w_px  = r_u * w_wm1;
    assign w_py  = r_v * w_hm1;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_O]) begin
            if (r_bad_r) begin
                o_face    <= '0;
                o_face_u  <= '0;
                o_face_v  <= '0;
                o_pixel_x <= '0;
                o_pixel_y <= '0;
            end else begin
                o_face    <= r_face_r;
                o_face_u  <= r_u;
                o_face_v  <= r_v;
                o_pixel_x <= w_px[COORD_FRAC_BITS+PIX_W-1:COORD_FRAC_BITS];
                o_pixel_y <= w_py[COORD_FRAC_BITS+PIX_W-1:COORD_FRAC_BITS];
            end
            o_bad_angle <= r_bad_r;
        end
    end

endmodule
`default_nettype wire

// ===== design/cfrm_checker.sv =====
`default_nettype none
`include "cube_face_ray_mapping_unit_macros.svh"
module cfrm_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 o_in_ready,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic [2:0]                           o_face,
    input wire logic [cfrm_pkg::COORD_FRAC_BITS:0]   o_face_u,
    input wire logic [cfrm_pkg::COORD_FRAC_BITS:0]   o_face_v,
    input wire logic [cfrm_pkg::PIX_W-1:0]           o_pixel_x,
    input wire logic [cfrm_pkg::PIX_W-1:0]           o_pixel_y,
    input wire logic                                 o_bad_angle
);
    import cfrm_pkg::*;

    // a stalled result holds
    `CFRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_face) && $stable(o_face_u) && $stable(o_pixel_x))

    // an angle error carries only zero fields
    `CFRM_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_bad_angle, o_face == FACE_FRONT && o_face_u == '0 && o_face_v == '0 && o_pixel_x == '0 && o_pixel_y == '0)

    // coordinates stay in 0..1 and faces in range
    `CFRM_ASSERT_IMPL(a_range, i_clk, i_rst_n, o_out_valid, o_face <= FACE_BOTTOM && o_face_u <= (1 << COORD_FRAC_BITS) && o_face_v <= (1 << COORD_FRAC_BITS))

    // an empty output register never blocks the input
    `CFRM_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind cube_face_ray_mapping_unit cfrm_checker u_cfrm_checker (.*);
`default_nettype wire

// ===== dv/cube_face_ray_mapping_unit_tb.sv =====
`timescale 1ns / 1ps
module cube_face_ray_mapping_unit_tb;
    import cfrm_pkg::*;

    localparam int LATENCY   = 37;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1700;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic [2:0]  face;
        logic [16:0] u;
        logic [16:0] v;
        logic [11:0] px;
        logic [11:0] py;
        logic        bad;
    } t_mapping;

    typedef struct packed {
        logic signed [14:0] az;
        logic signed [13:0] el;
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_MIN_AZ;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [14:0] i_azimuth = '0;
    logic signed [13:0] i_elevation = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [2:0] o_face;
    logic [16:0] o_face_u, o_face_v;
    logic [11:0] o_pixel_x, o_pixel_y;
    logic o_bad_angle;

    cube_face_ray_mapping_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers
    logic signed [14:0] min_az_q = '0;
    logic [12:0] width_q = 13'd1024;
    logic [12:0] height_q = 13'd1024;

    t_ray     pending_rays[$];
    t_mapping expected_maps[$];
    int errors = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_bad = 0;
    int face_hits[6] = '{default: 0};
    bit hold_off = 0;
    int hold_count = 0;
    bit sender_pause = 0;
    bit took = 0;
    int idle_cycles = 0;

    function automatic longint floor_sh(longint x, int s);
        return x >>> s;
    endfunction

    // CORDIC sine/cosine, Q16 angle in, Q24 out
    task automatic sincos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        int atan_tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
        flip = 0;
        if (ang >= 205887) ang -= 411775;
        if (ang < -205887) ang += 411775;
        if (ang > 102944) begin
            ang -= 205887; flip = 1;
        end else if (ang < -102944) begin
            ang += 205887; flip = 1;
        end
        x = 10188014; y = 0; z = ang;
        for (int i = 0; i < 16; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint coord_of(longint c, longint d);
        longint r;
        if (d == 0) return 32768;
        r = 32768 + (c * 32768) / d;
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    function automatic longint size_clamp(longint v);
        if (v < 1) return 1;
        if (v > MAX_FACE_SIZE) return MAX_FACE_SIZE;
        return v;
    endfunction

    task automatic predict_mapping(input t_ray r, output t_mapping m);
        longint rel, a16, ca, sa, ce, se, vx, vy, vz, ax, ay, avz, d, cu, cv, u, v;
        m = '0;
        rel = longint'(r.az) - longint'(min_az_q);
        if (rel < 0) begin
            m.bad = 1'b1;
            return;
        end
        a16 = rel * 16;
        sincos(a16 - 51472, ca, sa);
        sincos(longint'(r.el) * 16, ce, se);
        vx = floor_sh(ca * ce, 24);
        vy = floor_sh(sa * ce, 24);
        vz = se;
        ax = vx < 0 ? -vx : vx;
        ay = vy < 0 ? -vy : vy;
        avz = vz < 0 ? -vz : vz;
        if (avz > ax && avz > ay) m.face = vz >= 0 ? FACE_TOP : FACE_BOTTOM;
        else if (a16 < 102944) m.face = FACE_FRONT;
        else if (a16 < 205887) m.face = FACE_LEFT;
        else if (a16 < 308831) m.face = FACE_REAR;
        else m.face = FACE_RIGHT;
        case (m.face)
            FACE_FRONT: begin d = vx;  cu = -vy; cv = -vz; end
            FACE_LEFT:  begin d = vy;  cu = vx;  cv = -vz; end
            FACE_REAR:  begin d = -vx; cu = vy;  cv = -vz; end
            FACE_RIGHT: begin d = -vy; cu = -vx; cv = -vz; end
            FACE_TOP:   begin d = vz;  cu = -vy; cv = vx;  end
            default:    begin d = -vz; cu = -vy; cv = -vx; end
        endcase
        u = coord_of(cu, d);
        v = coord_of(cv, d);
        m.u = u[16:0];
        m.v = v[16:0];
        m.px = 12'((u * (size_clamp(width_q) - 1)) >> 16);
        m.py = 12'((v * (size_clamp(height_q) - 1)) >> 16);
    endtask

    // Register write, block idle
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MIN_AZ: min_az_q = val[14:0];
            CFG_WIDTH:  width_q = val[12:0];
            default:    height_q = val[12:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_rays.size() != 0 || expected_maps.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_ray rand_ray(bit wide);
        t_ray r;
        if (wide) begin
            r.az = 15'($urandom);
            r.el = 14'($urandom);
        end else begin
            r.az = 15'($signed($urandom_range(0, 25736)) - 12868);
            r.el = 14'($signed($urandom_range(0, 12868)) - 6434);
        end
        return r;
    endfunction

    // Driver: bursts and gaps, requests held until accepted
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || took) begin
                if (gap_left > 0 || sender_pause || pending_rays.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    i_azimuth <= pending_rays[0].az;
                    i_elevation <= pending_rays[0].el;
                    void'(pending_rays.pop_front());
                    i_in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Acceptance and prediction at the rising edge
    always @(posedge i_clk) begin
        t_mapping m;
        took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_mapping('{az: i_azimuth, el: i_elevation}, m);
            expected_maps.push_back(m);
            n_accepted++;
        end
    end

    // Receiver stall pattern, long hold-off counted here
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_off && hold_count < HOLD_LEN) begin
            i_out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else if ((stall_phase / 64) % 3 == 0) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor and checker
    always @(posedge i_clk) begin
        t_mapping e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_maps.size() == 0) begin
                $error("unexpected result face=%0d", o_face);
                errors++;
            end else begin
                e = expected_maps.pop_front();
                n_checked++;
                if (e.bad) n_bad++; else face_hits[e.face]++;
                if (o_face !== e.face) begin
                    $error("face exp %0d got %0d", e.face, o_face); errors++;
                end
                if (o_face_u !== e.u) begin
                    $error("face_u exp %0d got %0d", e.u, o_face_u); errors++;
                end
                if (o_face_v !== e.v) begin
                    $error("face_v exp %0d got %0d", e.v, o_face_v); errors++;
                end
                if (o_pixel_x !== e.px) begin
                    $error("pixel_x exp %0d got %0d", e.px, o_pixel_x); errors++;
                end
                if (o_pixel_y !== e.py) begin
                    $error("pixel_y exp %0d got %0d", e.py, o_pixel_y); errors++;
                end
                if (o_bad_angle !== e.bad) begin
                    $error("bad_angle exp %0d got %0d", e.bad, o_bad_angle); errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus: directed, then random phases over several register settings
    initial begin
        logic signed [14:0] az_ext[4] = '{15'sd12868, -15'sd12868, 15'sd0, 15'sd6434};
        logic signed [13:0] el_ext[5] = '{14'sd6434, -14'sd6434, 14'sd0, 14'sd3217, -14'sd8192};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, front/left/rear sectors, straight up/down, beyond half pi
        foreach (az_ext[a]) foreach (el_ext[b])
            pending_rays.push_back('{az: az_ext[a], el: el_ext[b]});
        pending_rays.push_back('{az: 15'sd6433, el: 14'sd0});
        pending_rays.push_back('{az: 15'sd3216, el: 14'sd0});
        pending_rays.push_back('{az: 15'sd16383, el: 14'sd8191});
        pending_rays.push_back('{az: -15'sd16384, el: 14'sd0});
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(CFG_MIN_AZ, -15'sd12868); write_reg(CFG_WIDTH, 13'd4096);
                         write_reg(CFG_HEIGHT, 13'd1); end
                1: begin write_reg(CFG_MIN_AZ, 15'sd12868); write_reg(CFG_WIDTH, 13'd0);
                         write_reg(CFG_HEIGHT, 13'd8191); end
                2: begin write_reg(CFG_MIN_AZ, 15'($urandom)); write_reg(CFG_WIDTH, 13'($urandom));
                         write_reg(CFG_HEIGHT, 13'($urandom)); end
                3: begin write_reg(CFG_MIN_AZ, -15'sd16384); write_reg(CFG_WIDTH, 13'd1);
                         write_reg(CFG_HEIGHT, 13'd4096); end
                4: begin write_reg(CFG_MIN_AZ, 15'sd16383); write_reg(CFG_WIDTH, 13'd640);
                         write_reg(CFG_HEIGHT, 13'd480); end
                default: begin write_reg(CFG_MIN_AZ, 15'sd0); write_reg(CFG_WIDTH, 13'd1024);
                         write_reg(CFG_HEIGHT, 13'd1024); end
            endcase
            for (int k = 0; k < N_RANDOM / 6; k++)
                pending_rays.push_back(rand_ray($urandom_range(0, 4) == 0));
            if (phase == 2) begin
                // long receiver hold-off while requests keep coming
                hold_off = 1;
                wait (hold_count >= HOLD_LEN);
                hold_off = 0;
            end
            if (phase == 4) begin
                while (pending_rays.size() > N_RANDOM / 12) @(posedge i_clk);
                sender_pause = 1;
                while (expected_maps.size() != 0 || i_in_valid) @(posedge i_clk);
                sender_pause = 0;
            end
            wait_drained();
        end
        $display("Sent %0d rays, checked %0d (%0d out of range) over 7 register settings",
                 n_accepted, n_checked, n_bad);
        $display("Face counts F/L/Re/Ri/T/B: %0d %0d %0d %0d %0d %0d", face_hits[0],
                 face_hits[1], face_hits[2], face_hits[3], face_hits[4], face_hits[5]);
        if (errors == 0 && expected_maps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
